FILE: sv/amet_pkg.sv
// ----------------------------------------------------------------------------
// amet_pkg
// Shared types and constants for the accelerometer motion episode timer.
// ----------------------------------------------------------------------------
package amet_pkg;

  localparam int AXIS_W     = 16;
  localparam int SUM_W      = 32;
  localparam int MAG_W      = 16;
  localparam int MOVE_W     = 17;
  localparam int TICKS_W    = 32;
  localparam int THR_W      = 16;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int REM_W      = MAG_W + 3;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd819;
  localparam logic             REG_THRESHOLD   = 1'b0;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [AXIS_W-1:0] abs_x;
    logic [AXIS_W-1:0] abs_y;
    logic [AXIS_W-1:0] abs_z;
  } queue_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DECIDE
  } back_state_t;

endpackage

FILE: sv/amet_front.sv
// ----------------------------------------------------------------------------
// amet_front
// Input stage: takes requests, tags ticks and samples, folds axes to
// magnitudes and hands entries to the queue.
// ----------------------------------------------------------------------------
module amet_front import amet_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  output logic                     push,
  output queue_entry_t             push_entry,
  input  logic                     queue_full
);

  logic         valid_r;
  queue_entry_t entry_r;
  queue_entry_t entry_nxt;
  logic         accept;

  function automatic logic [AXIS_W-1:0] fold(input logic [AXIS_W-1:0] v);
    fold = v[AXIS_W-1] ? (~v + 1'b1) : v;
  endfunction

  assign push     = valid_r && !queue_full;
  assign in_stall = valid_r && queue_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    entry_nxt.kind  = in_action ? KIND_TICK : KIND_SAMPLE;
    entry_nxt.abs_x = fold(in_accel_x);
    entry_nxt.abs_y = fold(in_accel_y);
    entry_nxt.abs_z = fold(in_accel_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

  assign push_entry = entry_r;

endmodule

FILE: sv/amet_queue.sv
// ----------------------------------------------------------------------------
// amet_queue
// Short FIFO between the front and back stages.
// ----------------------------------------------------------------------------
module amet_queue import amet_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  queue_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output queue_entry_t head,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  queue_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r;
  logic [PTR_W-1:0]       rd_ptr_r;
  logic [CNT_W-1:0]       count_r;
  logic                   do_push;
  logic                   do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/amet_isqrt.sv
// ----------------------------------------------------------------------------
// amet_isqrt
// Floor square root, one result bit per cycle by digit recurrence.
// ----------------------------------------------------------------------------
module amet_isqrt import amet_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] radicand,
  output sqrt_status_t     status,
  output logic [MAG_W-1:0] root
);

  logic [SUM_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [MAG_W-1:0]      root_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  fits;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SUM_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[MAG_W-2:0], fits};
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign root        = root_r;

endmodule

FILE: sv/amet_back.sv
// ----------------------------------------------------------------------------
// amet_back
// Execution stage: counts ticks, forms the sum of squares, runs the root,
// decides episode start and end and holds the result register.
// ----------------------------------------------------------------------------
module amet_back import amet_pkg::*; #(
  parameter int DURATION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [THR_W-1:0]         threshold,
  input  queue_entry_t             head,
  input  logic                     empty,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [MOVE_W-1:0] out_movement,
  output logic [MAG_W-1:0]         out_magnitude,
  output logic                     out_motion_active,
  output logic                     out_episode_started,
  output logic                     out_episode_ended,
  output logic [TICKS_W-1:0]       out_episode_ticks
);

  back_state_t              state_r;
  back_state_t              state_nxt;
  logic [1:0]               sq_idx_r;
  logic [AXIS_W-1:0]        ax_r;
  logic [AXIS_W-1:0]        ay_r;
  logic [AXIS_W-1:0]        az_r;
  logic [AXIS_W-1:0]        sq_sel;
  logic [SUM_W-1:0]         prod_r;
  logic [SUM_W-1:0]         acc_r;
  logic                     sqrt_start;
  sqrt_status_t             sqrt_status;
  logic [MAG_W-1:0]         root;
  logic [MAG_W-1:0]         prev_mag_r;
  logic                     running_r;
  logic [DURATION_BITS-1:0] tick_cnt_r;
  logic [TICKS_W-1:0]       dur_low;
  logic signed [MOVE_W-1:0] diff;
  logic [MOVE_W-1:0]        abs_diff;
  logic                     over;
  logic                     load_out;
  logic                     tick_pop;
  logic                     out_valid_r;

  amet_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_r + prod_r),
    .status   (sqrt_status),
    .root     (root)
  );

  generate
    if (DURATION_BITS >= TICKS_W) begin : g_dur_trunc
      assign dur_low = tick_cnt_r[TICKS_W-1:0];
    end else begin : g_dur_ext
      assign dur_low = {{(TICKS_W-DURATION_BITS){1'b0}}, tick_cnt_r};
    end
  endgenerate

  assign diff     = $signed({1'b0, root}) - $signed({1'b0, prev_mag_r});
  assign abs_diff = diff[MOVE_W-1] ? MOVE_W'(-diff) : MOVE_W'(diff);
  assign over     = (abs_diff > {1'b0, threshold});

  always_comb begin
    case (sq_idx_r)
      2'd0:    sq_sel = ax_r;
      2'd1:    sq_sel = ay_r;
      2'd2:    sq_sel = az_r;
      default: sq_sel = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    tick_pop   = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (head.kind == KIND_TICK) begin
            tick_pop = 1'b1;
          end else begin
            state_nxt = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (sq_idx_r == 2'd3) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_status.done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // squares: one product per cycle, the x and y products accumulated in the next cycle, z added at the root input
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      sq_idx_r <= '0;
      ax_r     <= head.abs_x;
      ay_r     <= head.abs_y;
      az_r     <= head.abs_z;
    end else if (state_r == ST_SQUARE) begin
      sq_idx_r <= sq_idx_r + 1'b1;
      prod_r   <= {{AXIS_W{1'b0}}, sq_sel} * {{AXIS_W{1'b0}}, sq_sel};
      if (sq_idx_r == 2'd0) begin
        acc_r <= '0;
      end else if (sq_idx_r != 2'd3) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mag_r <= '0;
      running_r  <= 1'b0;
      tick_cnt_r <= '0;
    end else if (tick_pop) begin
      if (running_r && (tick_cnt_r != '1)) begin
        tick_cnt_r <= tick_cnt_r + 1'b1;
      end
    end else if (load_out) begin
      prev_mag_r <= root;
      if (over) begin
        if (!running_r) begin
          running_r  <= 1'b1;
          tick_cnt_r <= '0;
        end
      end else if (running_r) begin
        running_r  <= 1'b0;
        tick_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_movement        <= diff;
      out_magnitude       <= root;
      out_motion_active   <= over;
      out_episode_started <= over && !running_r;
      out_episode_ended   <= !over && running_r;
      out_episode_ticks   <= (!over && running_r) ? dur_low : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/accel_motion_episode_timer_unit.sv
// ----------------------------------------------------------------------------
// accel_motion_episode_timer_unit
// Accelerometer magnitude motion detector with a tick-counted episode timer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  action, accel_x/y/z
//   out_     output     out_valid/out_stall movement, magnitude, flags, ticks
//   cfg      input      APB, pready high   movement_threshold at byte 0
//
// A tick is taken by the back end in its idle state as it leaves the queue.
// A sample holds the back end through dispatch, squaring, 16 root steps plus a
// done step, and the decision, in which its result is registered.
// Synchronous active-low reset clears the queue and episode state and restores the default threshold.
// Input stalls only when the front register holds an item and the queue is
// full; a stalled result holds the back end in its decision step.
// ----------------------------------------------------------------------------
module accel_motion_episode_timer_unit import amet_pkg::*; #(
  parameter int DURATION_BITS = 32,
  parameter int QUEUE_DEPTH   = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [MOVE_W-1:0] out_movement,
  output logic [MAG_W-1:0]         out_magnitude,
  output logic                     out_motion_active,
  output logic                     out_episode_started,
  output logic                     out_episode_ended,
  output logic [TICKS_W-1:0]       out_episode_ticks,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [THR_W-1:0] threshold_r;
  logic             push;
  queue_entry_t     push_entry;
  logic             queue_full;
  logic             pop;
  queue_entry_t     head;
  logic             empty;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'b0, threshold_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      threshold_r <= pwdata[THR_W-1:0];
    end
  end

  amet_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  amet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  amet_back #(
    .DURATION_BITS (DURATION_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .threshold           (threshold_r),
    .head                (head),
    .empty               (empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_movement        (out_movement),
    .out_magnitude       (out_magnitude),
    .out_motion_active   (out_motion_active),
    .out_episode_started (out_episode_started),
    .out_episode_ended   (out_episode_ended),
    .out_episode_ticks   (out_episode_ticks)
  );

endmodule

FILE: sv/amet_checker.sv
// ----------------------------------------------------------------------------
// amet_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module amet_checker import amet_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [MOVE_W-1:0] out_movement,
  input logic [MAG_W-1:0]         out_magnitude,
  input logic                     out_motion_active,
  input logic                     out_episode_started,
  input logic                     out_episode_ended,
  input logic [TICKS_W-1:0]       out_episode_ticks
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_magnitude) && $stable(out_movement)
      && $stable(out_episode_ticks))
    else $error("result changed while stalled");

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_episode_started |-> out_motion_active && !out_episode_ended)
    else $error("episode start without active flag");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_episode_ended |-> !out_motion_active)
    else $error("episode end with active flag");

  a_ticks_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_episode_ended |-> out_episode_ticks == '0)
    else $error("duration reported without episode end");

endmodule

bind accel_motion_episode_timer_unit amet_checker u_amet_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_movement        (out_movement),
  .out_magnitude       (out_magnitude),
  .out_motion_active   (out_motion_active),
  .out_episode_started (out_episode_started),
  .out_episode_ended   (out_episode_ended),
  .out_episode_ticks   (out_episode_ticks)
);
